// ===== rtl/sbit_pkg.sv =====
// Package for the segment/box touch test: widths, stream sizes and the
// structs passed between pipeline stages. No dependencies.
package sbit_pkg;

  localparam int COORD_BITS   = 24;
  localparam int DIFF_BITS    = COORD_BITS + 1;
  localparam int PROD_BITS    = 2 * DIFF_BITS;
  localparam int IN_FIELDS    = 8;
  localparam int IN_BITS      = IN_FIELDS * COORD_BITS;
  localparam int S_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_BITS = 8;

  // Request payload; start_x sits in the lowest bits.
  typedef struct packed {
    logic signed [COORD_BITS-1:0] box_max_y;
    logic signed [COORD_BITS-1:0] box_max_x;
    logic signed [COORD_BITS-1:0] box_min_y;
    logic signed [COORD_BITS-1:0] box_min_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_x;
  } seg_t;

  // Per-axis differences relative to the segment start.
  typedef struct packed {
    logic signed [DIFF_BITS-1:0] d;   // end - start
    logic signed [DIFF_BITS-1:0] lo;  // box min - start
    logic signed [DIFF_BITS-1:0] hi;  // box max - start
    logic                        box_ok;
  } diff_t;

  // Per-axis clip interval: entry ratio ne/mag, exit ratio nl/mag.
  typedef struct packed {
    logic signed [DIFF_BITS-1:0] ne;
    logic signed [DIFF_BITS-1:0] nl;
    logic [COORD_BITS-1:0]       mag;
    logic                        moving;
    logic                        ok;
  } axis_t;

  typedef struct packed {
    axis_t y;
    axis_t x;
  } clip_t;

endpackage

// ===== rtl/segment_box_intersection_test_core.sv =====
// Top level of the segment/box touch test: stream ports, payload unpacking
// and the two pipeline halves. Depends on sbit_pkg, sbit_slab, sbit_cross.
//
//   Port group  Dir  Payload (low bit first)
//   s_axis      in   start_x, start_y, end_x, end_y,
//                    box_min_x, box_min_y, box_max_x, box_max_y
//   m_axis      out  touches, zero padding to 8 bits
//
// One request enters per cycle unless m_axis stalls; its answer is presented
// on m_axis from the last of four register stages (differences, clip ratios,
// cross products, output).
// Each stage holds its valid bit and advances when the next stage is free,
// so a stall on m_axis fills bubbles first and then holds s_axis_tready low.
// Reset clears only the valid bits.
module segment_box_intersection_test_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // start_x, start_y, end_x, end_y, box_min_x, box_min_y, box_max_x, box_max_y
  input  logic [sbit_pkg::S_TDATA_BITS-1:0] s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // touches, then zero padding
  output logic [sbit_pkg::M_TDATA_BITS-1:0] m_axis_tdata_o
);

  sbit_pkg::seg_t  seg;
  sbit_pkg::clip_t clip;
  logic            clip_valid;
  logic            clip_ready;
  logic            touches;

  assign seg = sbit_pkg::seg_t'(s_axis_tdata_i[sbit_pkg::IN_BITS-1:0]);

  sbit_slab u_slab (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .seg_i       (seg),
    .out_valid_o (clip_valid),
    .out_ready_i (clip_ready),
    .clip_o      (clip)
  );

  sbit_cross u_cross (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (clip_valid),
    .in_ready_o  (clip_ready),
    .clip_i      (clip),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .touches_o   (touches)
  );

  assign m_axis_tdata_o = {{(sbit_pkg::M_TDATA_BITS-1){1'b0}}, touches};

endmodule

// ===== rtl/sbit_slab.sv =====
// First two pipeline stages: coordinate differences, then per-axis entry and
// exit ratios with the single-axis checks. Depends on sbit_pkg.
module sbit_slab (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sbit_pkg::seg_t      seg_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sbit_pkg::clip_t     clip_o
);

  logic            v1_q, v2_q;
  logic            rdy1, rdy2;
  sbit_pkg::diff_t dx_q, dx_d, dy_q, dy_d;
  sbit_pkg::clip_t clip_q, clip_d;

  function automatic sbit_pkg::axis_t clip_axis(sbit_pkg::diff_t df);
    sbit_pkg::axis_t             a;
    logic signed [sbit_pkg::DIFF_BITS-1:0] neg_d;
    neg_d    = -df.d;
    a.moving = (df.d != '0);
    if (df.d[sbit_pkg::DIFF_BITS-1]) begin
      a.mag = neg_d[sbit_pkg::COORD_BITS-1:0];
      a.ne  = -df.hi;
      a.nl  = -df.lo;
    end else begin
      a.mag = df.d[sbit_pkg::COORD_BITS-1:0];
      a.ne  = df.lo;
      a.nl  = df.hi;
    end
    // A moving axis needs a non-empty slab, exit at or after t=0 and entry
    // at or before t=1. A parallel axis needs the start inside the slab.
    if (a.moving) begin
      a.ok = df.box_ok && !a.nl[sbit_pkg::DIFF_BITS-1] &&
             (a.ne <= $signed({1'b0, a.mag}));
    end else begin
      a.ok = (df.lo[sbit_pkg::DIFF_BITS-1] || (df.lo == '0)) &&
             !df.hi[sbit_pkg::DIFF_BITS-1];
    end
    return a;
  endfunction

  assign rdy2        = !v2_q || out_ready_i;
  assign rdy1        = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign out_valid_o = v2_q;
  assign clip_o      = clip_q;

  always_comb begin
    dx_d.d      = sbit_pkg::DIFF_BITS'(seg_i.end_x) - sbit_pkg::DIFF_BITS'(seg_i.start_x);
    dx_d.lo     = sbit_pkg::DIFF_BITS'(seg_i.box_min_x) - sbit_pkg::DIFF_BITS'(seg_i.start_x);
    dx_d.hi     = sbit_pkg::DIFF_BITS'(seg_i.box_max_x) - sbit_pkg::DIFF_BITS'(seg_i.start_x);
    dx_d.box_ok = (seg_i.box_min_x <= seg_i.box_max_x);
    dy_d.d      = sbit_pkg::DIFF_BITS'(seg_i.end_y) - sbit_pkg::DIFF_BITS'(seg_i.start_y);
    dy_d.lo     = sbit_pkg::DIFF_BITS'(seg_i.box_min_y) - sbit_pkg::DIFF_BITS'(seg_i.start_y);
    dy_d.hi     = sbit_pkg::DIFF_BITS'(seg_i.box_max_y) - sbit_pkg::DIFF_BITS'(seg_i.start_y);
    dy_d.box_ok = (seg_i.box_min_y <= seg_i.box_max_y);
    clip_d.x    = clip_axis(dx_q);
    clip_d.y    = clip_axis(dy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= in_valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
    if (rdy2 && v1_q) begin
      clip_q <= clip_d;
    end
  end

endmodule

// ===== rtl/sbit_cross.sv =====
// Last two pipeline stages: cross-multiplied ratio products between the axes,
// then the final compare into the output register. Depends on sbit_pkg.
module sbit_cross (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sbit_pkg::clip_t clip_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            touches_o
);

  logic v3_q, vo_q;
  logic rdy3, rdyo;
  logic both_q, both_d;
  logic ok_q, ok_d;
  logic touches_q, touches_d;
  logic signed [sbit_pkg::PROD_BITS-1:0] ex_dy_q, ex_dy_d;
  logic signed [sbit_pkg::PROD_BITS-1:0] ly_dx_q, ly_dx_d;
  logic signed [sbit_pkg::PROD_BITS-1:0] ey_dx_q, ey_dx_d;
  logic signed [sbit_pkg::PROD_BITS-1:0] lx_dy_q, lx_dy_d;
  logic signed [sbit_pkg::DIFF_BITS-1:0] mag_x, mag_y;

  assign rdyo        = !vo_q || out_ready_i;
  assign rdy3        = !v3_q || rdyo;
  assign in_ready_o  = rdy3;
  assign out_valid_o = vo_q;
  assign touches_o   = touches_q;

  // Entry of one axis must not lie after exit of the other; all
  // denominators are positive, so the ratios compare by cross products.
  always_comb begin
    mag_x     = $signed({1'b0, clip_i.x.mag});
    mag_y     = $signed({1'b0, clip_i.y.mag});
    ex_dy_d   = clip_i.x.ne * mag_y;
    ly_dx_d   = clip_i.y.nl * mag_x;
    ey_dx_d   = clip_i.y.ne * mag_x;
    lx_dy_d   = clip_i.x.nl * mag_y;
    both_d    = clip_i.x.moving && clip_i.y.moving;
    ok_d      = clip_i.x.ok && clip_i.y.ok;
    touches_d = ok_q && (!both_q || ((ex_dy_q <= ly_dx_q) && (ey_dx_q <= lx_dy_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_q <= in_valid_i;
      end
      if (rdyo) begin
        vo_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && in_valid_i) begin
      ex_dy_q <= ex_dy_d;
      ly_dx_q <= ly_dx_d;
      ey_dx_q <= ey_dx_d;
      lx_dy_q <= lx_dy_d;
      both_q  <= both_d;
      ok_q    <= ok_d;
    end
    if (rdyo && v3_q) begin
      touches_q <= touches_d;
    end
  end

endmodule
